@@ src/first_match_ip_prefix_filter_unit_assert.svh @@
// Assertion macros used by the top-level filter unit.
// Standalone header; the users supply clock, reset and expressions.
`ifndef FIRST_MATCH_IP_PREFIX_FILTER_UNIT_ASSERT_SVH
`define FIRST_MATCH_IP_PREFIX_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FMPF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fmpf: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FMPF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fmpf: next-cycle check failed");

`endif

@@ src/fmpf_pkg.sv @@
// Package for the first-match IPv4 prefix filter: codes, widths and word types.
// Used by fmpf_cell and first_match_ip_prefix_filter_unit; depends on nothing.
`default_nettype none

package fmpf_pkg;

    localparam int unsigned DEF_ENTRIES = 16;
    localparam int unsigned MAX_ENTRIES = 1024;
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned PLEN_W      = 6;
    localparam int unsigned OUT_IDX_W   = 4;
    // Internal index and count widths cover the largest supported table.
    localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
    localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);

    typedef enum logic {
        REQ_LOOKUP = 1'b0,
        REQ_APPEND = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_PREFIX = 2'd1,
        ST_FULL       = 2'd2
    } t_status;

    typedef struct packed {
        t_req              req_type;
        logic [ADDR_W-1:0] address;
        logic [PLEN_W-1:0] prefix_len;
        logic              new_mode;
    } t_in_word;

    typedef struct packed {
        logic                 allowed;
        logic                 matched;
        logic [OUT_IDX_W-1:0] match_index;
        t_status              status;
    } t_out_word;

    // Word that travels down the chain of cells, one cell per cycle while the chain advances.
    typedef struct packed {
        logic              valid;
        t_req              req;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] mask;
        logic              mode;
        logic [CNT_W-1:0]  count;
        t_status           status;
        logic              found;
        logic              allow;
        logic [IDX_W-1:0]  index;
    } t_cell_word;

endpackage

`default_nettype wire

@@ src/fmpf_cell.sv @@
// One filter cell: holds a single table entry, stores an append aimed at it and checks a passing lookup against it.
// Depends on fmpf_pkg.
`default_nettype none

module fmpf_cell
    import fmpf_pkg::*;
#(
    parameter int unsigned INDEX = 0
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_advance,
    input  wire t_cell_word i_word,
    output t_cell_word      o_word
);

    logic [ADDR_W-1:0] r_value;
    logic [ADDR_W-1:0] r_mask;
    logic              r_allow;
    logic              r_valid;
    t_cell_word        r_word;
    t_cell_word        n_word;
    logic              n_write;
    logic              n_hit;

    // The word carries the table size seen when it was accepted, so a lookup
    // sees exactly the appends that came before it.
    assign n_write = i_word.valid && (i_word.req == REQ_APPEND) &&
                     (i_word.status == ST_OK) && (i_word.count == CNT_W'(INDEX));

    assign n_hit = i_word.valid && (i_word.req == REQ_LOOKUP) && !i_word.found &&
                   (CNT_W'(INDEX) < i_word.count) &&
                   ((i_word.address & r_mask) == r_value);

    always_comb begin
        n_word = i_word;
        if (n_hit) begin
            n_word.found = 1'b1;
            n_word.allow = r_allow;
            n_word.index = IDX_W'(INDEX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_word <= n_word;
        end
        if (i_advance && n_write) begin
            r_value <= i_word.address;
            r_mask  <= i_word.mask;
            r_allow <= i_word.mode;
        end
    end

    always_comb begin
        o_word       = r_word;
        o_word.valid = r_valid;
    end

endmodule

`default_nettype wire

@@ src/first_match_ip_prefix_filter_unit.sv @@
// A word moves one cell per advance of the chain; the last cell yields its result.
// Throughput: one word per cycle unless stalled; the chain length sets the latency.
// A stalled result holds the whole chain, and the input stalls with it.
// Reset empties the table (count zero) and clears every in-flight valid bit.
// Depends on fmpf_pkg, fmpf_cell and first_match_ip_prefix_filter_unit_assert.svh.
`default_nettype none

`include "first_match_ip_prefix_filter_unit_assert.svh"

module first_match_ip_prefix_filter_unit
    import fmpf_pkg::*;
#(
    parameter int unsigned ENTRIES = DEF_ENTRIES
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              n_advance;
    logic              n_accept;
    logic [ADDR_W-1:0] n_mask;
    t_status           n_status;
    t_cell_word        w_chain [ENTRIES+1];

    assign n_advance = !w_chain[ENTRIES].valid || !i_out_stall;
    assign o_in_stall = !n_advance;
    assign n_accept   = i_in_valid && n_advance;

    // Leading-ones mask; a shift by the full width yields zero, so 32 gives all ones.
    assign n_mask = ~({ADDR_W{1'b1}} >> i_in_word.prefix_len);

    always_comb begin
        n_status = ST_OK;
        if (i_in_word.req_type == REQ_APPEND) begin
            if (i_in_word.prefix_len > PLEN_W'(ADDR_W)) begin
                n_status = ST_BAD_PREFIX;
            end else if (r_count >= CNT_W'(ENTRIES)) begin
                n_status = ST_FULL;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (n_accept && (i_in_word.req_type == REQ_APPEND) && (n_status == ST_OK)) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_comb begin
        w_chain[0]         = '0;
        w_chain[0].valid   = i_in_valid;
        w_chain[0].req     = i_in_word.req_type;
        w_chain[0].address = i_in_word.address & n_mask;
        w_chain[0].mask    = n_mask;
        w_chain[0].mode    = i_in_word.new_mode;
        w_chain[0].count   = r_count;
        w_chain[0].status  = n_status;
        // A lookup compares the raw address against each stored entry.
        if (i_in_word.req_type == REQ_LOOKUP) begin
            w_chain[0].address = i_in_word.address;
        end
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        fmpf_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (n_advance),
            .i_word    (w_chain[g]),
            .o_word    (w_chain[g+1])
        );
    end

    assign o_out_valid             = w_chain[ENTRIES].valid;
    assign o_out_word.allowed      = w_chain[ENTRIES].found && w_chain[ENTRIES].allow;
    assign o_out_word.matched      = w_chain[ENTRIES].found;
    assign o_out_word.match_index  = w_chain[ENTRIES].index[OUT_IDX_W-1:0];
    assign o_out_word.status       = w_chain[ENTRIES].status;

    `FMPF_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(ENTRIES))
    `FMPF_ASSERT_NXT(a_count_step, i_clk, i_rst_n, n_accept && (i_in_word.req_type == REQ_APPEND) && (n_status == ST_OK), r_count == $past(r_count) + CNT_W'(1))
    `FMPF_ASSERT_IMP(a_deny_default, i_clk, i_rst_n, o_out_valid && !o_out_word.matched, !o_out_word.allowed && (o_out_word.match_index == '0))
    `FMPF_ASSERT_IMP(a_hold_on_stall, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall)

endmodule

`default_nettype wire
